### src/wsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_pkg
// Types and constants shared by the WAV stream parser modules.
// ----------------------------------------------------------------------------
package wsp_pkg;

  // Chunk and form tags, as they read when assembled little-endian.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_BODY_LEN = 32'd16;
  localparam logic [15:0] PCM_FORMAT   = 16'd1;
  localparam logic [15:0] PCM_BITS     = 16'd16;

  // Result queue depth; one byte can produce two results.
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_SAMPLE     = 3'd0,
    ST_HEADER_OK  = 3'd1,
    ST_NOT_RIFF   = 3'd2,
    ST_NOT_WAVE   = 3'd3,
    ST_NO_DATA    = 3'd4,
    ST_BAD_FORMAT = 3'd5,
    ST_BAD_BITS   = 3'd6,
    ST_DONE       = 3'd7
  } status_e;

  typedef struct packed {
    status_e            status;
    logic signed [15:0] sample;
    logic               channel;
    logic [31:0]        fmt_rate;
    logic [15:0]        channel_count;
    logic               last;
  } result_t;

  // Results produced by one accepted item, oldest in res0.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

### src/wsp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_parser
// Byte-wise RIFF/WAVE header walker and PCM16 sample assembler. Produces up to
// two results for every accepted byte.
// ----------------------------------------------------------------------------
module wsp_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           take_i,
  input  logic [7:0]     byte_value_i,
  input  logic           file_end_i,
  output wsp_pkg::push_t push_o
);

  typedef enum logic [3:0] {
    PH_RIFF     = 4'd0,
    PH_RSIZE    = 4'd1,
    PH_WAVE     = 4'd2,
    PH_CID      = 4'd3,
    PH_SZ_FMT   = 4'd4,
    PH_SZ_DATA  = 4'd5,
    PH_SZ_OTHER = 4'd6,
    PH_FMT_BODY = 4'd7,
    PH_SKIP     = 4'd8,
    PH_DATA     = 4'd9,
    PH_WAIT     = 4'd10
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  idx_q, idx_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] skip_q, skip_d;
  logic [15:0] format_q, format_d;
  logic [15:0] chans_q, chans_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] data_rem_q, data_rem_d;
  logic [7:0]  low_q, low_d;
  logic        side_q, side_d;

  logic [31:0] word;
  logic        word_done;
  logic [31:0] skip_dec, data_dec;
  logic [15:0] smp;
  logic        fin;
  logic        a_v, b_v, e_v;
  wsp_pkg::result_t res_a, res_b, res_e;
  wsp_pkg::push_t   push;

  always_comb begin
    word = shift_q;
    case (idx_q[1:0])
      2'd0:    word[7:0]   = shift_q[7:0]   | byte_value_i;
      2'd1:    word[15:8]  = shift_q[15:8]  | byte_value_i;
      2'd2:    word[23:16] = shift_q[23:16] | byte_value_i;
      default: word[31:24] = shift_q[31:24] | byte_value_i;
    endcase
  end

  assign word_done = (idx_q >= 4'd3);
  assign skip_dec  = (skip_q != '0) ? skip_q - 32'd1 : '0;
  assign data_dec  = (data_rem_q != '0) ? data_rem_q - 32'd1 : '0;
  assign smp       = {byte_value_i, low_q};

  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    shift_d    = shift_q;
    skip_d     = skip_q;
    format_d   = format_q;
    chans_d    = chans_q;
    rate_d     = rate_q;
    bits_d     = bits_q;
    data_rem_d = data_rem_q;
    low_d      = low_q;
    side_d     = side_q;
    fin        = 1'b0;
    a_v        = 1'b0;
    b_v        = 1'b0;
    e_v        = 1'b0;
    res_a      = '0;
    res_b      = '0;
    res_e      = '0;

    case (phase_q)
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID: begin
        if (word_done) begin
          idx_d   = '0;
          shift_d = '0;
          case (phase_q)
            PH_RIFF: begin
              if (word != wsp_pkg::TAG_RIFF) begin
                a_v          = 1'b1;
                res_a.status = wsp_pkg::ST_NOT_RIFF;
                res_a.last   = 1'b1;
                phase_d      = PH_WAIT;
                fin          = 1'b1;
              end else begin
                phase_d = PH_RSIZE;
              end
            end
            PH_RSIZE: phase_d = PH_WAVE;
            PH_WAVE: begin
              if (word != wsp_pkg::TAG_WAVE) begin
                a_v          = 1'b1;
                res_a.status = wsp_pkg::ST_NOT_WAVE;
                res_a.last   = 1'b1;
                phase_d      = PH_WAIT;
                fin          = 1'b1;
              end else begin
                phase_d = PH_CID;
              end
            end
            default: begin
              if (word == wsp_pkg::TAG_FMT) begin
                phase_d = PH_SZ_FMT;
              end else if (word == wsp_pkg::TAG_DATA) begin
                phase_d = PH_SZ_DATA;
              end else begin
                phase_d = PH_SZ_OTHER;
              end
            end
          endcase
        end else begin
          idx_d   = idx_q + 4'd1;
          shift_d = word;
        end
      end

      PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER: begin
        if (word_done) begin
          idx_d   = '0;
          shift_d = '0;
          if (phase_q == PH_SZ_FMT) begin
            skip_d  = word;
            phase_d = PH_FMT_BODY;
          end else if (phase_q == PH_SZ_OTHER) begin
            skip_d  = word;
            phase_d = (word == '0) ? PH_CID : PH_SKIP;
          end else begin
            data_rem_d = word;
            a_v        = 1'b1;
            if (word == '0 || format_q != wsp_pkg::PCM_FORMAT ||
                bits_q != wsp_pkg::PCM_BITS) begin
              if (word == '0) begin
                res_a.status = wsp_pkg::ST_NO_DATA;
              end else if (format_q != wsp_pkg::PCM_FORMAT) begin
                res_a.status = wsp_pkg::ST_BAD_FORMAT;
              end else begin
                res_a.status = wsp_pkg::ST_BAD_BITS;
              end
              res_a.last = 1'b1;
              phase_d    = PH_WAIT;
              fin        = 1'b1;
            end else begin
              res_a.status        = wsp_pkg::ST_HEADER_OK;
              res_a.fmt_rate      = rate_q;
              res_a.channel_count = chans_q;
              if (chans_q == '0) begin
                // No channels: the header is all there is.
                b_v          = 1'b1;
                res_b.status = wsp_pkg::ST_DONE;
                res_b.last   = 1'b1;
                phase_d      = PH_WAIT;
                fin          = 1'b1;
              end else begin
                phase_d = PH_DATA;
                side_d  = 1'b0;
              end
            end
          end
        end else begin
          idx_d   = idx_q + 4'd1;
          shift_d = word;
        end
      end

      PH_FMT_BODY: begin
        case (idx_q)
          4'd0:    format_d = {8'd0, byte_value_i};
          4'd1:    format_d = format_q | {byte_value_i, 8'd0};
          4'd2:    chans_d  = {8'd0, byte_value_i};
          4'd3:    chans_d  = chans_q | {byte_value_i, 8'd0};
          4'd4:    rate_d   = {24'd0, byte_value_i};
          4'd5:    rate_d   = rate_q | {16'd0, byte_value_i, 8'd0};
          4'd6:    rate_d   = rate_q | {8'd0, byte_value_i, 16'd0};
          4'd7:    rate_d   = rate_q | {byte_value_i, 24'd0};
          4'd14:   bits_d   = {8'd0, byte_value_i};
          4'd15:   bits_d   = bits_q | {byte_value_i, 8'd0};
          default: ;
        endcase
        if (idx_q == 4'd15) begin
          idx_d = '0;
          // The first sixteen body bytes are always read, whatever the size says.
          if (skip_q > wsp_pkg::FMT_BODY_LEN) begin
            skip_d  = skip_q - wsp_pkg::FMT_BODY_LEN;
            phase_d = PH_SKIP;
          end else begin
            skip_d  = '0;
            phase_d = PH_CID;
          end
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end

      PH_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          phase_d = PH_CID;
        end
      end

      PH_DATA: begin
        data_rem_d = data_dec;
        if (idx_q == '0) begin
          low_d = byte_value_i;
          idx_d = 4'd1;
        end else begin
          idx_d        = '0;
          a_v          = 1'b1;
          res_a.status = wsp_pkg::ST_SAMPLE;
          res_a.sample = smp;
          if (chans_q == 16'd1) begin
            // A mono sample goes out on both sides, left first.
            b_v           = 1'b1;
            res_b.status  = wsp_pkg::ST_SAMPLE;
            res_b.sample  = smp;
            res_b.channel = 1'b1;
          end else begin
            res_a.channel = side_q;
            side_d        = ~side_q;
          end
        end
        if (data_dec == '0 || file_end_i) begin
          if (b_v) begin
            res_b.last = 1'b1;
          end else if (a_v) begin
            res_a.last = 1'b1;
          end else begin
            a_v          = 1'b1;
            res_a.status = wsp_pkg::ST_DONE;
            res_a.last   = 1'b1;
          end
          phase_d = PH_WAIT;
          fin     = 1'b1;
        end
      end

      default: ;
    endcase

    // A file that ends early reports where it stopped.
    if (file_end_i && !fin) begin
      res_e.last = 1'b1;
      case (phase_d)
        PH_RIFF: begin
          e_v          = 1'b1;
          res_e.status = wsp_pkg::ST_NOT_RIFF;
        end
        PH_RSIZE, PH_WAVE: begin
          e_v          = 1'b1;
          res_e.status = wsp_pkg::ST_NOT_WAVE;
        end
        PH_DATA: begin
          e_v          = 1'b1;
          res_e.status = wsp_pkg::ST_DONE;
        end
        PH_WAIT: e_v = 1'b0;
        default: begin
          e_v          = 1'b1;
          res_e.status = wsp_pkg::ST_NO_DATA;
        end
      endcase
    end

    if (file_end_i) begin
      phase_d    = PH_RIFF;
      idx_d      = '0;
      shift_d    = '0;
      skip_d     = '0;
      format_d   = '0;
      chans_d    = '0;
      rate_d     = '0;
      bits_d     = '0;
      data_rem_d = '0;
      low_d      = '0;
      side_d     = 1'b0;
    end

    push = '0;
    if (a_v) begin
      push.res0 = res_a;
      if (b_v) begin
        push.res1  = res_b;
        push.count = 2'd2;
      end else if (e_v) begin
        push.res1  = res_e;
        push.count = 2'd2;
      end else begin
        push.count = 2'd1;
      end
    end else if (e_v) begin
      push.res0  = res_e;
      push.count = 2'd1;
    end
    if (!take_i) begin
      push.count = 2'd0;
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_RIFF;
      idx_q      <= '0;
      shift_q    <= '0;
      skip_q     <= '0;
      format_q   <= '0;
      chans_q    <= '0;
      rate_q     <= '0;
      bits_q     <= '0;
      data_rem_q <= '0;
      low_q      <= '0;
      side_q     <= 1'b0;
    end else if (take_i) begin
      phase_q    <= phase_d;
      idx_q      <= idx_d;
      shift_q    <= shift_d;
      skip_q     <= skip_d;
      format_q   <= format_d;
      chans_q    <= chans_d;
      rate_q     <= rate_d;
      bits_q     <= bits_d;
      data_rem_q <= data_rem_d;
      low_q      <= low_d;
      side_q     <= side_d;
    end
  end

endmodule

### src/wsp_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_out_fifo
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module wsp_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wsp_pkg::push_t   push_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output wsp_pkg::result_t out_res_o
);

  wsp_pkg::result_t entry_q [wsp_pkg::OUT_DEPTH];

  logic [wsp_pkg::OUT_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [wsp_pkg::OUT_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [wsp_pkg::OUT_CNT_W-1:0] count_q, count_d;
  logic [wsp_pkg::OUT_PTR_W-1:0] wr_next;
  logic                          pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_res_o   = entry_q[rd_ptr_q];
  // Room is judged on the registered count so that two results always fit.
  assign room_o      = (count_q <= wsp_pkg::OUT_CNT_W'(wsp_pkg::OUT_DEPTH - 2));
  assign wr_next     = wr_ptr_q + wsp_pkg::OUT_PTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + wsp_pkg::OUT_PTR_W'(push_i.count);
    rd_ptr_d = pop ? rd_ptr_q + wsp_pkg::OUT_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + wsp_pkg::OUT_CNT_W'(push_i.count)
             - wsp_pkg::OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      entry_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      entry_q[wr_next] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### src/wav_stream_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_stream_parser_core
// RIFF/WAVE byte stream parser with 16-bit PCM sample output.
// ----------------------------------------------------------------------------
// One file byte is taken per item, one item per clock cycle while the queue has
// room, and its results are written into a four-entry result queue in the same
// cycle. A byte is accepted whenever the queue holds at most two results, and
// the queue delivers one result per cycle while out_ready_i is high, so a
// stereo stream runs at one byte a cycle and a mono stream, with two results
// for every two bytes, also sustains one byte a cycle. The header result, or a
// format or no-data error, comes out once the data chunk size has been read;
// a file_end byte resets the parser for the next file.
module wav_stream_parser_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         byte_value_i,
  input  logic               file_end_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic signed [15:0] sample_o,
  output logic               channel_o,
  output logic [31:0]        fmt_rate_o,
  output logic [15:0]        channel_count_o,
  output logic               last_o
);

  logic             take;
  logic             room;
  wsp_pkg::push_t   push;
  wsp_pkg::result_t res;

  assign in_ready_o = room;
  assign take       = in_valid_i && room;

  wsp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .byte_value_i (byte_value_i),
    .file_end_i   (file_end_i),
    .push_o       (push)
  );

  wsp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (res)
  );

  assign status_o        = res.status;
  assign sample_o        = res.sample;
  assign channel_o       = res.channel;
  assign fmt_rate_o      = res.fmt_rate;
  assign channel_count_o = res.channel_count;
  assign last_o          = res.last;

endmodule

### src/wsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_checker
// Port-level checks on the result channel of the WAV stream parser.
// ----------------------------------------------------------------------------
module wsp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [2:0]         status_o,
  input logic signed [15:0] sample_o,
  input logic               channel_o,
  input logic [31:0]        fmt_rate_o,
  input logic [15:0]        channel_count_o,
  input logic               last_o
);

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(sample_o) && $stable(last_o))
    else $error("result changed while stalled");

  // Sample fields are zero on anything that is not a sample.
  a_no_stray_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != wsp_pkg::ST_SAMPLE |-> sample_o == '0 && !channel_o)
    else $error("sample field set on a non-sample item");

  // Header fields only travel with a header ok item, which never closes a file.
  a_header_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != wsp_pkg::ST_HEADER_OK |->
      fmt_rate_o == '0 && channel_count_o == '0)
    else $error("header field set on a non-header item");

  // Errors and done always close the file.
  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != wsp_pkg::ST_SAMPLE &&
      status_o != wsp_pkg::ST_HEADER_OK |-> last_o)
    else $error("closing status without last");

endmodule

bind wav_stream_parser_core wsp_checker u_wsp_checker (.*);

### verif/tb_wav_stream_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wav_stream_parser_core
// Self-checking bench for the WAV stream parser core. Whole RIFF/WAVE files
// are generated byte by byte (well-formed, truncated, noisy and mistagged)
// and fed through the byte channel. A parser model in the bench predicts the
// header, error, sample and done results that each byte produces, and every
// result that the core delivers is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_wav_stream_parser_core;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned LONG_STALL     = 400;
  localparam int unsigned PHASE_BYTES    = 430;
  localparam int unsigned TAIL_CYCLES    = 20;

  typedef enum logic [3:0] {
    WALK_RIFF,
    WALK_RSIZE,
    WALK_WAVE,
    WALK_CHUNK_ID,
    WALK_FMT_SIZE,
    WALK_DATA_SIZE,
    WALK_OTHER_SIZE,
    WALK_FMT_BODY,
    WALK_SKIP,
    WALK_DATA,
    WALK_IGNORE
  } walk_e;

  typedef struct packed {
    logic [7:0] value;
    logic       eof;
  } file_byte_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [7:0]         byte_value_i = 8'd0;
  logic               file_end_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [2:0]         status_o;
  logic signed [15:0] sample_o;
  logic               channel_o;
  logic [31:0]        fmt_rate_o;
  logic [15:0]        channel_count_o;
  logic               last_o;

  wav_stream_parser_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_value_i   (byte_value_i),
    .file_end_i     (file_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .sample_o       (sample_o),
    .channel_o      (channel_o),
    .fmt_rate_o     (fmt_rate_o),
    .channel_count_o(channel_count_o),
    .last_o         (last_o)
  );

  file_byte_t        file_bytes_pending [$];
  logic [7:0]        file_build [$];
  wsp_pkg::result_t  due_results [$];
  file_byte_t        offered;
  logic              byte_taken = 1'b0;
  int unsigned       bytes_queued = 0;
  int unsigned       bytes_accepted = 0;
  int unsigned       errors = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       sender_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       stall_requests = 0;
  int unsigned       stalls_served = 0;
  int unsigned       stall_left = 0;

  // Parser model state.
  walk_e       walk_phase;
  logic [3:0]  word_idx;
  logic [31:0] word_acc;
  logic [31:0] skip_left;
  logic [15:0] fmt_code;
  logic [15:0] chan_count;
  logic [31:0] rate_val;
  logic [15:0] bits_val;
  logic [31:0] data_left;
  logic [7:0]  sample_lo;
  logic        next_side;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic reset_walk();
    walk_phase = WALK_RIFF;
    word_idx   = '0;
    word_acc   = '0;
    skip_left  = '0;
    fmt_code   = '0;
    chan_count = '0;
    rate_val   = '0;
    bits_val   = '0;
    data_left  = '0;
    sample_lo  = '0;
    next_side  = 1'b0;
  endtask

  function automatic wsp_pkg::result_t mk_result(wsp_pkg::status_e st, logic [15:0] smp,
                                                 logic side, logic [31:0] rate,
                                                 logic [15:0] cnt, logic fin);
    wsp_pkg::result_t r;
    r.status        = st;
    r.sample        = smp;
    r.channel       = side;
    r.fmt_rate      = rate;
    r.channel_count = cnt;
    r.last          = fin;
    return r;
  endfunction

  // Shifts one byte into the little-endian word; true once four have arrived.
  function automatic logic take_word_byte(input logic [7:0] b);
    word_acc = word_acc | ({24'd0, b} << (8 * word_idx[1:0]));
    word_idx = word_idx + 4'd1;
    return word_idx >= 4'd4;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic eof);
    wsp_pkg::result_t made [2];
    int               n;
    logic             file_over;
    logic [31:0]      size;
    n = 0;
    file_over = 1'b0;
    case (walk_phase)
      WALK_RIFF: begin
        if (take_word_byte(b)) begin
          if (word_acc != wsp_pkg::TAG_RIFF) begin
            made[n] = mk_result(wsp_pkg::ST_NOT_RIFF, '0, 1'b0, '0, '0, 1'b1);
            n++;
            walk_phase = WALK_IGNORE;
            file_over = 1'b1;
          end else begin
            walk_phase = WALK_RSIZE;
          end
          word_idx = '0;
          word_acc = '0;
        end
      end
      WALK_RSIZE: begin
        if (take_word_byte(b)) begin
          walk_phase = WALK_WAVE;
          word_idx = '0;
          word_acc = '0;
        end
      end
      WALK_WAVE: begin
        if (take_word_byte(b)) begin
          if (word_acc != wsp_pkg::TAG_WAVE) begin
            made[n] = mk_result(wsp_pkg::ST_NOT_WAVE, '0, 1'b0, '0, '0, 1'b1);
            n++;
            walk_phase = WALK_IGNORE;
            file_over = 1'b1;
          end else begin
            walk_phase = WALK_CHUNK_ID;
          end
          word_idx = '0;
          word_acc = '0;
        end
      end
      WALK_CHUNK_ID: begin
        if (take_word_byte(b)) begin
          if (word_acc == wsp_pkg::TAG_FMT) walk_phase = WALK_FMT_SIZE;
          else if (word_acc == wsp_pkg::TAG_DATA) walk_phase = WALK_DATA_SIZE;
          else walk_phase = WALK_OTHER_SIZE;
          word_idx = '0;
          word_acc = '0;
        end
      end
      WALK_FMT_SIZE, WALK_DATA_SIZE, WALK_OTHER_SIZE: begin
        if (take_word_byte(b)) begin
          size = word_acc;
          word_idx = '0;
          word_acc = '0;
          if (walk_phase == WALK_FMT_SIZE) begin
            skip_left = size;
            walk_phase = WALK_FMT_BODY;
          end else if (walk_phase == WALK_OTHER_SIZE) begin
            skip_left = size;
            walk_phase = (size == 32'd0) ? WALK_CHUNK_ID : WALK_SKIP;
          end else begin
            data_left = size;
            if (size == 32'd0 || fmt_code != wsp_pkg::PCM_FORMAT ||
                bits_val != wsp_pkg::PCM_BITS) begin
              if (size == 32'd0)
                made[n] = mk_result(wsp_pkg::ST_NO_DATA, '0, 1'b0, '0, '0, 1'b1);
              else if (fmt_code != wsp_pkg::PCM_FORMAT)
                made[n] = mk_result(wsp_pkg::ST_BAD_FORMAT, '0, 1'b0, '0, '0, 1'b1);
              else made[n] = mk_result(wsp_pkg::ST_BAD_BITS, '0, 1'b0, '0, '0, 1'b1);
              n++;
              walk_phase = WALK_IGNORE;
              file_over = 1'b1;
            end else begin
              made[n] = mk_result(wsp_pkg::ST_HEADER_OK, '0, 1'b0, rate_val, chan_count,
                                  1'b0);
              n++;
              if (chan_count == 16'd0) begin
                made[n] = mk_result(wsp_pkg::ST_DONE, '0, 1'b0, '0, '0, 1'b1);
                n++;
                walk_phase = WALK_IGNORE;
                file_over = 1'b1;
              end else begin
                walk_phase = WALK_DATA;
                next_side = 1'b0;
              end
            end
          end
        end
      end
      WALK_FMT_BODY: begin
        // Sixteen body bytes are always taken as fields, whatever the size says.
        case (word_idx)
          4'd0:    fmt_code = {8'd0, b};
          4'd1:    fmt_code[15:8] = b;
          4'd2:    chan_count = {8'd0, b};
          4'd3:    chan_count[15:8] = b;
          4'd4:    rate_val = {24'd0, b};
          4'd5:    rate_val[15:8] = b;
          4'd6:    rate_val[23:16] = b;
          4'd7:    rate_val[31:24] = b;
          4'd14:   bits_val = {8'd0, b};
          4'd15:   bits_val[15:8] = b;
          default: ;
        endcase
        if (word_idx == 4'd15) begin
          word_idx = '0;
          if (skip_left > wsp_pkg::FMT_BODY_LEN) begin
            skip_left = skip_left - wsp_pkg::FMT_BODY_LEN;
            walk_phase = WALK_SKIP;
          end else begin
            skip_left = '0;
            walk_phase = WALK_CHUNK_ID;
          end
        end else begin
          word_idx = word_idx + 4'd1;
        end
      end
      WALK_SKIP: begin
        if (skip_left != 32'd0) skip_left = skip_left - 32'd1;
        if (skip_left == 32'd0) walk_phase = WALK_CHUNK_ID;
      end
      WALK_DATA: begin
        if (data_left != 32'd0) data_left = data_left - 32'd1;
        if (word_idx == 4'd0) begin
          sample_lo = b;
          word_idx = 4'd1;
        end else begin
          word_idx = 4'd0;
          if (chan_count == 16'd1) begin
            made[n] = mk_result(wsp_pkg::ST_SAMPLE, {b, sample_lo}, 1'b0, '0, '0, 1'b0);
            n++;
            made[n] = mk_result(wsp_pkg::ST_SAMPLE, {b, sample_lo}, 1'b1, '0, '0, 1'b0);
            n++;
          end else begin
            made[n] = mk_result(wsp_pkg::ST_SAMPLE, {b, sample_lo}, next_side, '0, '0,
                                1'b0);
            n++;
            next_side = ~next_side;
          end
        end
        if (data_left == 32'd0 || eof) begin
          if (n > 0) made[n-1].last = 1'b1;
          else begin
            made[n] = mk_result(wsp_pkg::ST_DONE, '0, 1'b0, '0, '0, 1'b1);
            n++;
          end
          walk_phase = WALK_IGNORE;
          file_over = 1'b1;
        end
      end
      default: ;
    endcase

    // A file cut short reports where it stopped.
    if (eof && !file_over) begin
      case (walk_phase)
        WALK_RIFF: begin
          made[n] = mk_result(wsp_pkg::ST_NOT_RIFF, '0, 1'b0, '0, '0, 1'b1);
          n++;
        end
        WALK_RSIZE, WALK_WAVE: begin
          made[n] = mk_result(wsp_pkg::ST_NOT_WAVE, '0, 1'b0, '0, '0, 1'b1);
          n++;
        end
        WALK_DATA: begin
          made[n] = mk_result(wsp_pkg::ST_DONE, '0, 1'b0, '0, '0, 1'b1);
          n++;
        end
        WALK_IGNORE: ;
        default: begin
          made[n] = mk_result(wsp_pkg::ST_NO_DATA, '0, 1'b0, '0, '0, 1'b1);
          n++;
        end
      endcase
    end
    if (eof) reset_walk();
    for (int k = 0; k < n; k++) due_results.push_back(made[k]);
  endtask

  task automatic check_result(input wsp_pkg::result_t got, input wsp_pkg::result_t want);
    if (got.status != want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errors++;
    end
    if (got.sample != want.sample) begin
      $error("sample: expected %0d, got %0d", want.sample, got.sample);
      errors++;
    end
    if (got.channel != want.channel) begin
      $error("channel: expected %0d, got %0d", want.channel, got.channel);
      errors++;
    end
    if (got.fmt_rate != want.fmt_rate) begin
      $error("fmt_rate: expected %0d, got %0d", want.fmt_rate, got.fmt_rate);
      errors++;
    end
    if (got.channel_count != want.channel_count) begin
      $error("channel_count: expected %0d, got %0d", want.channel_count,
             got.channel_count);
      errors++;
    end
    if (got.last != want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      errors++;
    end
  endtask

  // Sender: a new item is offered only once the previous one has gone.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || byte_taken)) begin
      if (file_bytes_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        offered = file_bytes_pending.pop_front();
        in_valid_i   <= 1'b1;
        byte_value_i <= offered.value;
        file_end_i   <= offered.eof;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver, with an occasional long hold-off on request.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_requests != stalls_served) begin
      stalls_served = stall_requests;
      stall_left = LONG_STALL;
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    wsp_pkg::result_t got;
    if (rst_ni) begin
      byte_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        parse_byte(byte_value_i, file_end_i);
        bytes_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        got = mk_result(wsp_pkg::status_e'(status_o), sample_o, channel_o, fmt_rate_o,
                        channel_count_o, last_o);
        if (due_results.size() == 0) begin
          $error("result with nothing expected: status %0d, sample %0d", status_o, sample_o);
          errors++;
        end else begin
          check_result(got, due_results.pop_front());
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_wav_stream_parser_core failed");
        $finish;
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(19))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic put_byte(input logic [7:0] b);
    file_build.push_back(b);
  endtask

  task automatic put_half(input logic [15:0] h);
    put_byte(h[7:0]);
    put_byte(h[15:8]);
  endtask

  task automatic put_word(input logic [31:0] w);
    put_half(w[15:0]);
    put_half(w[31:16]);
  endtask

  // Hands the first keep bytes of the built file to the sender, the last one
  // marked as the end of the file.
  task automatic ship_file(input int keep);
    file_byte_t fb;
    for (int k = 0; k < keep; k++) begin
      fb.value = file_build[k];
      fb.eof   = (k == keep - 1);
      file_bytes_pending.push_back(fb);
    end
    bytes_queued += keep;
    file_build.delete();
  endtask

  task automatic put_other_chunk();
    logic [31:0] id;
    int          len;
    id = $urandom();
    if (id == wsp_pkg::TAG_FMT || id == wsp_pkg::TAG_DATA) id = id ^ 32'h1;
    len = $urandom_range(0, 6);
    put_word(id);
    put_word(len);
    for (int k = 0; k < len; k++) put_byte(pick_byte());
  endtask

  task automatic build_wave_file();
    int          fmt_len;
    int          body;
    int          pick;
    logic [31:0] data_len;
    logic [15:0] chans;
    put_word(wsp_pkg::TAG_RIFF);
    put_word($urandom());
    put_word(wsp_pkg::TAG_WAVE);
    if ($urandom_range(99) < 30) put_other_chunk();
    if ($urandom_range(99) < 92) begin
      fmt_len = ($urandom_range(99) < 80) ? 16 : $urandom_range(0, 24);
      put_word(wsp_pkg::TAG_FMT);
      put_word(fmt_len);
      put_half(($urandom_range(99) < 88) ? wsp_pkg::PCM_FORMAT :
               16'($urandom_range(65535)));
      pick = $urandom_range(99);
      if (pick < 45) chans = 16'd1;
      else if (pick < 85) chans = 16'd2;
      else if (pick < 90) chans = 16'd0;
      else chans = 16'($urandom_range(3, 65535));
      put_half(chans);
      put_word($urandom());
      put_word($urandom());
      put_half(16'($urandom_range(65535)));
      put_half(($urandom_range(99) < 88) ? wsp_pkg::PCM_BITS :
               16'($urandom_range(65535)));
      for (int k = 16; k < fmt_len; k++) put_byte(pick_byte());
    end
    if ($urandom_range(99) < 25) put_other_chunk();
    put_word(wsp_pkg::TAG_DATA);
    pick = $urandom_range(99);
    if (pick < 5) begin
      data_len = 32'd0;
      body = $urandom_range(0, 3);
    end else if (pick < 85) begin
      data_len = $urandom_range(1, 48);
      body = data_len;
      if ($urandom_range(99) < 20) body += $urandom_range(1, 3);
      else if ($urandom_range(99) < 12) body = $urandom_range(0, data_len);
    end else begin
      data_len = (pick < 95) ? (32'hFFFF_FF00 | $urandom_range(255)) : $urandom();
      body = $urandom_range(0, 40);
    end
    put_word(data_len);
    for (int k = 0; k < body; k++) put_byte(pick_byte());
  endtask

  task automatic build_random_file(output int keep);
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      build_wave_file();
      keep = file_build.size();
    end else if (pick < 85) begin
      build_wave_file();
      keep = $urandom_range(1, file_build.size());
    end else if (pick < 94) begin
      keep = $urandom_range(1, 12);
      for (int k = 0; k < keep; k++) put_byte(pick_byte());
    end else begin
      put_word(wsp_pkg::TAG_RIFF);
      put_word($urandom());
      put_word($urandom());
      for (int k = $urandom_range(0, 3); k > 0; k--) put_byte(pick_byte());
      keep = file_build.size();
    end
  endtask

  task automatic wait_drained();
    while (bytes_accepted != bytes_queued || due_results.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    int keep;
    int phase_bytes;
    reset_walk();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Short files that stop in the RIFF tag, carry a wrong RIFF tag, stop in
    // the RIFF size, and carry a wrong WAVE tag.
    put_byte(8'hFF);
    ship_file(file_build.size());
    put_word(wsp_pkg::TAG_RIFF ^ 32'h0200_0000);
    put_byte(8'h00);
    ship_file(file_build.size());
    put_word(wsp_pkg::TAG_RIFF);
    put_half(16'hFFFF);
    ship_file(file_build.size());
    put_word(wsp_pkg::TAG_RIFF);
    put_word(32'hFFFF_FFFF);
    put_word(wsp_pkg::TAG_WAVE ^ 32'h0000_0001);
    put_byte(8'h00);
    ship_file(file_build.size());
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 87;
          recv_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 87;
        end
        default: begin
          sender_idle_pct = 7;
          recv_stall_pct  = 7;
        end
      endcase
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        build_random_file(keep);
        ship_file(keep);
        phase_bytes += keep;
      end
      // The output side holds off while bytes keep coming, so the result
      // queue fills and the byte input has to stall.
      if (phase == 0) stall_requests++;
      // The sender then pauses until every outstanding result has been seen.
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (errors == 0 && due_results.size() == 0) begin
      $display("tb_wav_stream_parser_core passed");
    end else begin
      $display("tb_wav_stream_parser_core failed");
    end
    $finish;
  end

endmodule
